FILE: design/mpid_pkg.sv
`default_nettype none

package mpid_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int IN_SIZE_W  = 15;
   localparam int OUT_SIZE_W = 14;
   localparam int ACC_W      = 16;
   // wide enough for every size compare, including a maximum of 65536
   localparam int CMP_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam int MAX_IN_WIDTH_DEF   = 16384;
   localparam int MAX_IN_HEIGHT_DEF  = 16384;
   localparam int MAX_OUT_WIDTH_DEF  = 8192;
   localparam int MAX_OUT_HEIGHT_DEF = 8192;

   localparam logic [IN_SIZE_W-1:0]  IN_WIDTH_RST   = IN_SIZE_W'(16384);
   localparam logic [IN_SIZE_W-1:0]  IN_HEIGHT_RST  = IN_SIZE_W'(16384);
   localparam logic [OUT_SIZE_W-1:0] OUT_WIDTH_RST  = OUT_SIZE_W'(8192);
   localparam logic [OUT_SIZE_W-1:0] OUT_HEIGHT_RST = OUT_SIZE_W'(8192);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IN_WIDTH   = 2'd0,
      CSR_IN_HEIGHT  = 2'd1,
      CSR_OUT_WIDTH  = 2'd2,
      CSR_OUT_HEIGHT = 2'd3
   } csr_index_type;

   // flags of one closed horizontal cell
   typedef struct packed {
      logic band_first;
      logic to_out;
      logic row_end;
      logic frame_end;
   } mpid_op_type;

   typedef struct packed {
      logic s2_valid;
      logic fwd_valid;
   } mpid_stat_type;

endpackage

`default_nettype wire

FILE: design/mpid_req_if.sv
`default_nettype none

interface mpid_req_if;
   logic                          valid;
   logic                          ready;
   logic [mpid_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: design/mpid_rsp_if.sv
`default_nettype none

interface mpid_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mpid_pkg::SAMPLE_W-1:0] peak_sample;
   logic                          row_end;
   logic                          frame_end;

   modport source (output valid, output peak_sample, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input peak_sample, input row_end, input frame_end,
                   output ready);
endinterface

`default_nettype wire

FILE: design/mpid_ram.sv
`default_nettype none

module mpid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic                             re,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output      logic [WIDTH-1:0]                 rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

FILE: design/mpid_cursor.sv
`default_nettype none

module mpid_cursor #(
   parameter int MAX_IN_WIDTH   = mpid_pkg::MAX_IN_WIDTH_DEF,
   parameter int MAX_IN_HEIGHT  = mpid_pkg::MAX_IN_HEIGHT_DEF,
   parameter int MAX_OUT_WIDTH  = mpid_pkg::MAX_OUT_WIDTH_DEF,
   parameter int MAX_OUT_HEIGHT = mpid_pkg::MAX_OUT_HEIGHT_DEF,
   localparam int OC_W = $clog2(MAX_OUT_WIDTH > 1 ? MAX_OUT_WIDTH : 2)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [mpid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mpid_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                accept,
   input  wire logic [mpid_pkg::SAMPLE_W-1:0]       sample,
   output      logic                                op_valid,
   output      mpid_pkg::mpid_op_type               op,
   output      logic [mpid_pkg::SAMPLE_W-1:0]       op_peak,
   output      logic [OC_W-1:0]                     op_idx
);

   localparam int COL_W = $clog2(MAX_IN_WIDTH);
   localparam int ROW_W = $clog2(MAX_IN_HEIGHT);
   localparam int CW    = mpid_pkg::CMP_W;
   localparam int AW    = mpid_pkg::ACC_W;

   logic [mpid_pkg::IN_SIZE_W-1:0]  in_width_ff, in_height_ff;
   logic [mpid_pkg::OUT_SIZE_W-1:0] out_width_ff, out_height_ff;

   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [AW-1:0]                 hacc_ff, hacc_in, vacc_ff, vacc_in;
   logic [mpid_pkg::SAMPLE_W-1:0] peak_ff, peak_in;
   logic [OC_W-1:0]               ocol_ff, ocol_in;
   logic                          band_first_ff, band_first_in;
   logic                          closes_band_ff, closes_band_in;

   logic [CW-1:0] iw_c, ih_c, ow_c, oh_c, ow_hi, oh_hi, iw_raw, ih_raw, ow_raw, oh_raw;
   logic [AW-1:0] iw_a, ih_a, ow_a, oh_a;
   logic          last_col, last_row, closes_band, h_over, cell_close;
   logic [AW-1:0] vacc_cur, hacc_cur;
   logic [mpid_pkg::SAMPLE_W-1:0] peak_cur;

   // effective sizes: zero reads as one, then saturate
   always_comb begin
      iw_raw = CW'(in_width_ff);
      ih_raw = CW'(in_height_ff);
      ow_raw = CW'(out_width_ff);
      oh_raw = CW'(out_height_ff);
      if (iw_raw == '0) iw_c = CW'(1);
      else if (iw_raw > CW'(MAX_IN_WIDTH)) iw_c = CW'(MAX_IN_WIDTH);
      else iw_c = iw_raw;
      if (ih_raw == '0) ih_c = CW'(1);
      else if (ih_raw > CW'(MAX_IN_HEIGHT)) ih_c = CW'(MAX_IN_HEIGHT);
      else ih_c = ih_raw;
      ow_hi = (iw_c < CW'(MAX_OUT_WIDTH)) ? iw_c : CW'(MAX_OUT_WIDTH);
      oh_hi = (ih_c < CW'(MAX_OUT_HEIGHT)) ? ih_c : CW'(MAX_OUT_HEIGHT);
      if (ow_raw == '0) ow_c = CW'(1);
      else if (ow_raw > ow_hi) ow_c = ow_hi;
      else ow_c = ow_raw;
      if (oh_raw == '0) oh_c = CW'(1);
      else if (oh_raw > oh_hi) oh_c = oh_hi;
      else oh_c = oh_raw;
      // all four fit 15 bits since they never exceed the written register
      iw_a = AW'(iw_c[mpid_pkg::IN_SIZE_W-1:0]);
      ih_a = AW'(ih_c[mpid_pkg::IN_SIZE_W-1:0]);
      ow_a = AW'(ow_c[mpid_pkg::IN_SIZE_W-1:0]);
      oh_a = AW'(oh_c[mpid_pkg::IN_SIZE_W-1:0]);
   end

   always_comb begin
      last_col = CW'(col_ff) >= (iw_c - CW'(1));
      last_row = CW'(row_ff) >= (ih_c - CW'(1));
      vacc_cur = vacc_ff;
      closes_band = closes_band_ff;
      if (col_ff == '0) begin
         vacc_cur    = vacc_ff + oh_a;
         closes_band = (vacc_cur >= ih_a) || last_row;
      end
      peak_cur   = (sample > peak_ff) ? sample : peak_ff;
      hacc_cur   = hacc_ff + ow_a;
      h_over     = hacc_cur >= iw_a;
      cell_close = h_over || last_col;

      op_valid     = accept && cell_close;
      op.band_first = band_first_ff;
      op.to_out    = closes_band;
      op.row_end   = last_col;
      op.frame_end = last_col && last_row;
      op_peak      = peak_cur;
      op_idx       = ocol_ff;

      col_in         = col_ff;
      row_in         = row_ff;
      hacc_in        = hacc_ff;
      vacc_in        = vacc_ff;
      peak_in        = peak_ff;
      ocol_in        = ocol_ff;
      band_first_in  = band_first_ff;
      closes_band_in = closes_band_ff;
      if (accept) begin
         vacc_in = vacc_cur;
         peak_in = peak_cur;
         hacc_in = hacc_cur;
         if (cell_close) begin
            if (h_over) hacc_in = hacc_cur - iw_a;
            peak_in = '0;
            if (CW'(ocol_ff) < CW'(MAX_OUT_WIDTH - 1)) ocol_in = ocol_ff + OC_W'(1);
         end
         if (last_col) begin
            col_in  = '0;
            hacc_in = '0;
            peak_in = '0;
            ocol_in = '0;
            closes_band_in = 1'b0;
            if (closes_band) begin
               band_first_in = 1'b1;
               if (vacc_cur >= ih_a) vacc_in = vacc_cur - ih_a;
            end else begin
               band_first_in = 1'b0;
            end
            if (last_row) begin
               row_in        = '0;
               vacc_in       = '0;
               band_first_in = 1'b1;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in         = col_ff + COL_W'(1);
            closes_band_in = closes_band;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff    <= mpid_pkg::IN_WIDTH_RST;
         in_height_ff   <= mpid_pkg::IN_HEIGHT_RST;
         out_width_ff   <= mpid_pkg::OUT_WIDTH_RST;
         out_height_ff  <= mpid_pkg::OUT_HEIGHT_RST;
         col_ff         <= '0;
         row_ff         <= '0;
         hacc_ff        <= '0;
         vacc_ff        <= '0;
         peak_ff        <= '0;
         ocol_ff        <= '0;
         band_first_ff  <= 1'b1;
         closes_band_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (mpid_pkg::csr_index_type'(csr_index))
            mpid_pkg::CSR_IN_WIDTH:   in_width_ff   <= csr_wdata;
            mpid_pkg::CSR_IN_HEIGHT:  in_height_ff  <= csr_wdata;
            mpid_pkg::CSR_OUT_WIDTH:  out_width_ff  <= csr_wdata[mpid_pkg::OUT_SIZE_W-1:0];
            mpid_pkg::CSR_OUT_HEIGHT: out_height_ff <= csr_wdata[mpid_pkg::OUT_SIZE_W-1:0];
            default: ;
         endcase
         // any write restarts the frame
         col_ff         <= '0;
         row_ff         <= '0;
         hacc_ff        <= '0;
         vacc_ff        <= '0;
         peak_ff        <= '0;
         ocol_ff        <= '0;
         band_first_ff  <= 1'b1;
         closes_band_ff <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         hacc_ff        <= hacc_in;
         vacc_ff        <= vacc_in;
         peak_ff        <= peak_in;
         ocol_ff        <= ocol_in;
         band_first_ff  <= band_first_in;
         closes_band_ff <= closes_band_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/mpid_merge.sv
`default_nettype none

module mpid_merge #(
   parameter int MAX_OUT_WIDTH = mpid_pkg::MAX_OUT_WIDTH_DEF,
   localparam int OC_W = $clog2(MAX_OUT_WIDTH > 1 ? MAX_OUT_WIDTH : 2)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          op_valid,
   input  wire mpid_pkg::mpid_op_type         op,
   input  wire logic [mpid_pkg::SAMPLE_W-1:0] op_peak,
   input  wire logic [OC_W-1:0]               op_idx,
   output      logic                          s2_free,
   input  wire logic [mpid_pkg::SAMPLE_W-1:0] ram_rdata,
   output      logic                          ram_we,
   output      logic [OC_W-1:0]               ram_waddr,
   output      logic [mpid_pkg::SAMPLE_W-1:0] ram_wdata,
   output      mpid_pkg::mpid_stat_type       stat,
   mpid_rsp_if.source                         rsp
);

   logic                          s2_valid_ff, s2_valid_in;
   mpid_pkg::mpid_op_type         s2_op_ff;
   logic [mpid_pkg::SAMPLE_W-1:0] s2_peak_ff;
   logic [OC_W-1:0]               s2_idx_ff;
   logic                          fwd_valid_ff;
   logic [mpid_pkg::SAMPLE_W-1:0] fwd_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mpid_pkg::SAMPLE_W-1:0] rsp_peak_ff;
   logic                          rsp_row_end_ff, rsp_frame_end_ff;

   logic                          out_free, s2_go, hit;
   logic [mpid_pkg::SAMPLE_W-1:0] prev, merged;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp.ready;
      s2_go     = s2_valid_ff && (!s2_op_ff.to_out || out_free);
      s2_free   = !s2_valid_ff || s2_go;
      // a buffer write to the address read in the same cycle is forwarded
      prev      = fwd_valid_ff ? fwd_data_ff : ram_rdata;
      merged    = (!s2_op_ff.band_first && (prev > s2_peak_ff)) ? prev : s2_peak_ff;
      ram_we    = s2_go && !s2_op_ff.to_out;
      ram_waddr = s2_idx_ff;
      ram_wdata = merged;
      hit       = op_valid && !op.band_first && ram_we && (s2_idx_ff == op_idx);
      s2_valid_in  = op_valid || (s2_valid_ff && !s2_go);
      rsp_valid_in = (s2_go && s2_op_ff.to_out) || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (op_valid) fwd_valid_ff <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (op_valid) begin
         s2_op_ff    <= op;
         s2_peak_ff  <= op_peak;
         s2_idx_ff   <= op_idx;
         fwd_data_ff <= merged;
      end
      if (s2_go && s2_op_ff.to_out) begin
         rsp_peak_ff      <= merged;
         rsp_row_end_ff   <= s2_op_ff.row_end;
         rsp_frame_end_ff <= s2_op_ff.frame_end;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.peak_sample = rsp_peak_ff;
   assign rsp.row_end     = rsp_row_end_ff;
   assign rsp.frame_end   = rsp_frame_end_ff;
   assign stat.s2_valid   = s2_valid_ff;
   assign stat.fwd_valid  = fwd_valid_ff;

endmodule

`default_nettype wire

FILE: design/max_preserving_image_downscaler.sv
`default_nettype none

// channel   dir  handshake      payload
// req_chan  in   valid/ready    sample[7:0]
// rsp_chan  out  valid/ready    peak_sample[7:0], row_end, frame_end
// csr_*     in   csr_we         csr_index[1:0], csr_wdata[14:0]
//
// One sample per cycle while req ready is high. A sample's cell position and
// running maximum are settled in the cycle of its transfer; a closed cell is
// then registered, merged with its column buffer entry (one RAM read port,
// registered) and either lands in the output register, if it closes a band,
// or is written back to the buffer. Reset is synchronous; the column buffer is
// not cleared. req ready drops only while a closed cell waits for a stalled rsp.

module max_preserving_image_downscaler #(
   parameter int MAX_IN_WIDTH   = mpid_pkg::MAX_IN_WIDTH_DEF,
   parameter int MAX_IN_HEIGHT  = mpid_pkg::MAX_IN_HEIGHT_DEF,
   parameter int MAX_OUT_WIDTH  = mpid_pkg::MAX_OUT_WIDTH_DEF,
   parameter int MAX_OUT_HEIGHT = mpid_pkg::MAX_OUT_HEIGHT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mpid_req_if.sink                             req_chan,
   mpid_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [mpid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mpid_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int OC_W = $clog2(MAX_OUT_WIDTH > 1 ? MAX_OUT_WIDTH : 2);

   logic                          accept, op_valid, s2_free;
   mpid_pkg::mpid_op_type         op;
   logic [mpid_pkg::SAMPLE_W-1:0] op_peak, ram_rdata, ram_wdata;
   logic [OC_W-1:0]               op_idx, ram_waddr;
   logic                          ram_we, ram_re;
   mpid_pkg::mpid_stat_type       stat;

   assign req_chan.ready = s2_free;
   assign accept         = req_chan.valid && s2_free;
   assign ram_re         = op_valid && !op.band_first;

   mpid_cursor #(
      .MAX_IN_WIDTH   (MAX_IN_WIDTH),
      .MAX_IN_HEIGHT  (MAX_IN_HEIGHT),
      .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
      .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .sample    (req_chan.sample),
      .op_valid  (op_valid),
      .op        (op),
      .op_peak   (op_peak),
      .op_idx    (op_idx)
   );

   mpid_ram #(
      .WIDTH (mpid_pkg::SAMPLE_W),
      .DEPTH (MAX_OUT_WIDTH)
   ) u_column_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr    (op_idx),
      .rdata_ff (ram_rdata)
   );

   mpid_merge #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .op_peak   (op_peak),
      .op_idx    (op_idx),
      .s2_free   (s2_free),
      .ram_rdata (ram_rdata),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .stat      (stat),
      .rsp       (rsp_chan)
   );

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_end |-> rsp_chan.row_end)
      else $error("frame end without row end");

   a_fwd_capture: assert property (@(posedge clock) disable iff (reset)
      ram_we && ram_re && (ram_waddr == op_idx) |=> stat.fwd_valid)
      else $error("same-address buffer write not forwarded");

   a_stall_has_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> stat.s2_valid && rsp_chan.valid)
      else $error("input stalled with no pending cell");

endmodule

`default_nettype wire

FILE: tb/max_preserving_image_downscaler_tb.sv
`default_nettype none

module max_preserving_image_downscaler_tb;
   import mpid_pkg::*;

   localparam int QUIET_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int TOTAL_ITEMS   = 600;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic [SAMPLE_W-1:0] peak;
      logic                row_end;
      logic                frame_end;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid  = 1'b0;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_ready  = 1'b0;
   logic                  csr_we     = 1'b0;
   csr_index_type         csr_index  = CSR_IN_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   mpid_req_if req_if ();
   mpid_rsp_if rsp_if ();

   assign req_if.valid  = req_valid;
   assign req_if.sample = req_sample;
   assign rsp_if.ready  = rsp_ready;

   max_preserving_image_downscaler dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expected results
   logic [SAMPLE_W-1:0] sample_queue [$];
   result_type          pending_cells [$];
   int queued = 0;
   int taken = 0;
   int results_seen = 0;
   int errors = 0;
   int quiet = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic hold_armed = 1'b0;

   // predictor copy of the registers and the scan state
   logic [IN_SIZE_W-1:0]  cfg_in_width, cfg_in_height;
   logic [OUT_SIZE_W-1:0] cfg_out_width, cfg_out_height;
   int                    scan_col, scan_row, cell_col;
   logic [ACC_W-1:0]      h_sum, v_sum;
   logic [SAMPLE_W-1:0]   cell_max;
   logic                  band_start, band_closing;
   logic [SAMPLE_W-1:0]   band_maxima [MAX_OUT_WIDTH_DEF];

   function automatic int eff_in_size(input int v, input int cap);
      return (v < 1) ? 1 : (v > cap) ? cap : v;
   endfunction

   function automatic int eff_out_size(input int v, input int in_size, input int cap);
      int hi;
      hi = (in_size < cap) ? in_size : cap;
      return (v < 1) ? 1 : (v > hi) ? hi : v;
   endfunction

   function automatic void restart_frame();
      scan_col     = 0;
      scan_row     = 0;
      h_sum        = '0;
      v_sum        = '0;
      cell_max     = '0;
      cell_col     = 0;
      band_start   = 1'b1;
      band_closing = 1'b0;
   endfunction

   function automatic void downscale_sample(input logic [SAMPLE_W-1:0] s);
      int iw, ih, ow, oh;
      logic last_col, last_row;
      logic [SAMPLE_W-1:0] merged;
      result_type predicted;
      iw = eff_in_size(int'(cfg_in_width), MAX_IN_WIDTH_DEF);
      ih = eff_in_size(int'(cfg_in_height), MAX_IN_HEIGHT_DEF);
      ow = eff_out_size(int'(cfg_out_width), iw, MAX_OUT_WIDTH_DEF);
      oh = eff_out_size(int'(cfg_out_height), ih, MAX_OUT_HEIGHT_DEF);
      last_col = scan_col >= iw - 1;
      last_row = scan_row >= ih - 1;

      if (scan_col == 0) begin
         v_sum = v_sum + ACC_W'(oh);
         band_closing = (int'(v_sum) >= ih) || last_row;
      end

      if (s > cell_max) cell_max = s;
      h_sum = h_sum + ACC_W'(ow);

      if ((int'(h_sum) >= iw) || last_col) begin
         merged = cell_max;
         if (int'(h_sum) >= iw) h_sum = h_sum - ACC_W'(iw);
         if (!band_start && band_maxima[cell_col] > merged) merged = band_maxima[cell_col];
         if (band_closing) begin
            predicted.peak      = merged;
            predicted.row_end   = last_col;
            predicted.frame_end = last_col && last_row;
            pending_cells.push_back(predicted);
         end else begin
            band_maxima[cell_col] = merged;
         end
         cell_max = '0;
         if (cell_col < MAX_OUT_WIDTH_DEF - 1) cell_col++;
      end

      if (last_col) begin
         scan_col = 0;
         h_sum    = '0;
         cell_max = '0;
         cell_col = 0;
         if (band_closing) begin
            band_start = 1'b1;
            if (int'(v_sum) >= ih) v_sum = v_sum - ACC_W'(ih);
         end else begin
            band_start = 1'b0;
         end
         if (last_row) begin
            scan_row   = 0;
            v_sum      = '0;
            band_start = 1'b1;
         end else begin
            scan_row++;
         end
         band_closing = 1'b0;
      end else begin
         scan_col++;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("mismatch at result %0d: %s", results_seen, msg);
   endtask

   // mostly random gaps, now and then a stretch with none
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // sample driver
   int send_gap = 0;
   int send_burst = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_fire) begin
            // offered item still waits for its transfer
         end else begin
            if (req_valid) send_gap = draw_gap(send_burst);
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               req_sample <= sample_queue.pop_front();
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver
   int recv_gap = 0;
   int recv_burst = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_fire) recv_gap = draw_gap(recv_burst);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predicts on every sample transfer, checks every result transfer
   always @(posedge clock) begin
      result_type want;
      req_fire <= !reset && req_valid && req_if.ready;
      rsp_fire <= !reset && rsp_if.valid && rsp_ready;
      if (reset) begin
         cfg_in_width   = IN_WIDTH_RST;
         cfg_in_height  = IN_HEIGHT_RST;
         cfg_out_width  = OUT_WIDTH_RST;
         cfg_out_height = OUT_HEIGHT_RST;
         restart_frame();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IN_WIDTH:   cfg_in_width   = csr_wdata[IN_SIZE_W-1:0];
               CSR_IN_HEIGHT:  cfg_in_height  = csr_wdata[IN_SIZE_W-1:0];
               CSR_OUT_WIDTH:  cfg_out_width  = csr_wdata[OUT_SIZE_W-1:0];
               CSR_OUT_HEIGHT: cfg_out_height = csr_wdata[OUT_SIZE_W-1:0];
            endcase
            restart_frame();
         end
         if (req_valid && req_if.ready) begin
            downscale_sample(req_sample);
            taken++;
         end
         if (rsp_if.valid && rsp_ready) begin
            if (pending_cells.size() == 0) begin
               report_mismatch($sformatf("unexpected result, peak %0d", rsp_if.peak_sample));
            end else begin
               want = pending_cells.pop_front();
               if (rsp_if.peak_sample !== want.peak)
                  report_mismatch($sformatf("peak_sample %0d, expected %0d",
                                            rsp_if.peak_sample, want.peak));
               if (rsp_if.row_end !== want.row_end)
                  report_mismatch($sformatf("row_end %0b, expected %0b",
                                            rsp_if.row_end, want.row_end));
               if (rsp_if.frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %0b, expected %0b",
                                            rsp_if.frame_end, want.frame_end));
            end
            results_seen++;
         end
         if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready) || csr_we) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
               $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   task automatic queue_sample(input logic [SAMPLE_W-1:0] v);
      sample_queue.push_back(v);
      queued++;
   endtask

   task automatic queue_random(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 7);
         if (pick == 0) queue_sample(8'd0);
         else if (pick == 1) queue_sample(8'd255);
         else queue_sample(SAMPLE_W'($urandom_range(0, 255)));
      end
   endtask

   // everything transferred, checked, and the pipeline has gone quiet
   task automatic wait_drained();
      while (!(sample_queue.size() == 0 && taken == queued && pending_cells.size() == 0))
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
   endtask

   task automatic configure(input int iw, input int ih, input int ow, input int oh);
      wait_drained();
      write_reg(CSR_IN_WIDTH, iw);
      write_reg(CSR_IN_HEIGHT, ih);
      write_reg(CSR_OUT_WIDTH, ow);
      write_reg(CSR_OUT_HEIGHT, oh);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int iw, ih, ow, oh, frame, n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // output larger than input: identity map
      configure(3, 2, 16383, 16383);
      queue_sample(8'd0);
      queue_sample(8'd255);
      queue_sample(8'd1);
      queue_sample(8'd128);
      queue_sample(8'd254);
      queue_sample(8'd127);

      // zero sizes act as 1x1 frames
      configure(0, 0, 0, 0);
      queue_sample(8'd200);
      queue_sample(8'd7);

      // 4x3 into 2x1, maxima spread over rows so the column buffer merges
      configure(4, 3, 2, 1);
      queue_sample(8'd9);   queue_sample(8'd3);   queue_sample(8'd0);   queue_sample(8'd200);
      queue_sample(8'd1);   queue_sample(8'd50);  queue_sample(8'd255); queue_sample(8'd7);
      queue_sample(8'd60);  queue_sample(8'd2);   queue_sample(8'd100); queue_sample(8'd4);

      // oversized input sizes saturate, output sizes lose their top bit then saturate;
      // each frame is cut short by the next write
      configure(32767, 1, 32767, 1);
      queue_random(40);
      configure(1, 32767, 1, 32767);
      queue_random(40);

      // start of a row at the largest width, cut short by the next write
      configure(MAX_IN_WIDTH_DEF, 1, 1, 1);
      queue_random(100);

      // identity frames with the receiver held off to back up the input
      configure(8, 6, 8, 6);
      hold_armed = 1'b1;
      queue_random(96);

      while (queued < TOTAL_ITEMS) begin
         iw = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         ih = $urandom_range(1, 8);
         ow = $urandom_range(1, iw + 2);
         oh = $urandom_range(1, ih + 2);
         if ($urandom_range(0, 11) == 0) iw = 0;
         if ($urandom_range(0, 11) == 0) ih = 0;
         if ($urandom_range(0, 11) == 0) ow = 0;
         if ($urandom_range(0, 11) == 0) oh = 0;
         // bit 14 is dropped by the output size registers
         if ($urandom_range(0, 7) == 0) ow += 16384;
         if ($urandom_range(0, 7) == 0) oh += 16384;
         frame = ((iw == 0) ? 1 : iw) * ((ih == 0) ? 1 : ih);
         if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2 * frame);
         else n = frame * $urandom_range(1, 3);
         if (n > TOTAL_ITEMS - queued) n = TOTAL_ITEMS - queued;
         configure(iw, ih, ow, oh);
         queue_random(n);
      end

      wait_drained();
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
design/mpid_pkg.sv
design/mpid_req_if.sv
design/mpid_rsp_if.sv
design/mpid_ram.sv
design/mpid_cursor.sv
design/mpid_merge.sv
design/max_preserving_image_downscaler.sv
tb/max_preserving_image_downscaler_tb.sv
